// ===== rtl/rrss_pkg.sv =====
package rrss_pkg;

  localparam int MaxProc = 16;
  localparam int IdxW    = (MaxProc > 1) ? $clog2(MaxProc) : 1;
  localparam int CntW    = $clog2(MaxProc + 1);

  localparam int SliceW  = 16;
  localparam int ClockW  = 21;
  localparam int TimeW   = 20;
  localparam int SumW    = 24;
  localparam int NumW    = 5;

  // one table entry: remaining time on top, original burst below
  localparam int EntryW  = 2 * SliceW;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_GRANT = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_LOADED   = 2'd0,
    KIND_GRANTED  = 2'd1,
    KIND_IDLE     = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [SliceW-1:0] burst_length;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [NumW-1:0]  process_number;
    logic [TimeW-1:0] slice_start;
    logic [TimeW-1:0] slice_end;
    logic             process_done;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic [SumW-1:0]  total_turnaround;
    logic [SumW-1:0]  total_waiting;
    logic [NumW-1:0]  finished_number;
  } out_t;

endpackage

// ===== rtl/rrss_ram.sv =====
module rrss_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/round_robin_slice_scheduler_core.sv =====
// channel   direction  handshake                    payload
// in        input      in_valid_i / in_stall_o      in_data_i  (rrss_pkg::in_t)
// out       output     out_valid_o / out_stall_i    out_data_o (rrss_pkg::out_t)
// cfg       input      cfg_we_i                     cfg_data_i (time slice)
//
// load, clear and idle items are handled on acceptance, as is a grant with nothing left to run;
// any other grant reads the table on acceptance and then does the read-modify-write
// of the entry in the table ram in the execute state.
// one item is in flight at a time; the input stalls while a grant executes
// or while a finished result waits on a stalled output.
// reset empties the table by clearing the live bitmap; no ram sweep is needed.
module round_robin_slice_scheduler_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rrss_pkg::in_t          in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rrss_pkg::out_t         out_data_o,
  input  logic                   cfg_we_i,
  input  logic [rrss_pkg::SliceW-1:0] cfg_data_i
);

  rrss_pkg::state_e state_q, state_d;

  logic [rrss_pkg::SliceW-1:0]  time_slice_q;
  logic [rrss_pkg::MaxProc-1:0] alive_q, alive_d;
  logic [rrss_pkg::CntW-1:0]    loaded_q, loaded_d;
  logic [rrss_pkg::CntW-1:0]    done_q, done_d;
  logic [rrss_pkg::IdxW-1:0]    next_q, next_d;
  logic [rrss_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [rrss_pkg::ClockW-1:0]  clock_q, clock_d;
  logic                         started_q, started_d;
  logic [rrss_pkg::SumW-1:0]    sum_tat_q, sum_tat_d;
  logic [rrss_pkg::SumW-1:0]    sum_wt_q, sum_wt_d;
  logic                         out_valid_q, out_valid_d;
  rrss_pkg::out_t               out_q, out_d;

  logic                         in_accept;
  logic [rrss_pkg::IdxW-1:0]    sel;
  logic                         any_alive;

  logic                         ram_we;
  logic [rrss_pkg::IdxW-1:0]    ram_waddr;
  logic [rrss_pkg::EntryW-1:0]  ram_wdata;
  logic                         ram_re;
  logic [rrss_pkg::EntryW-1:0]  ram_rdata;

  logic [rrss_pkg::SliceW-1:0]  ts_eff;
  logic [rrss_pkg::SliceW-1:0]  rem;
  logic [rrss_pkg::SliceW-1:0]  burst;
  logic [rrss_pkg::SliceW-1:0]  run;
  logic [rrss_pkg::SliceW-1:0]  rem_new;
  logic [rrss_pkg::ClockW-1:0]  clock_new;
  logic [rrss_pkg::ClockW-1:0]  wait_new;
  logic                         finish;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign any_alive   = |alive_q;

  // cyclic find-next over the live bitmap, starting at the next pointer
  always_comb begin
    int pos;
    sel = '0;
    for (int k = rrss_pkg::MaxProc - 1; k >= 0; k--) begin
      pos = int'(next_q) + k;
      if (pos >= rrss_pkg::MaxProc) begin
        pos = pos - rrss_pkg::MaxProc;
      end
      if (alive_q[pos]) begin
        sel = rrss_pkg::IdxW'(pos);
      end
    end
  end

  // execute stage arithmetic on the entry read from the table
  assign ts_eff    = (time_slice_q == '0) ? rrss_pkg::SliceW'(1) : time_slice_q;
  assign rem       = ram_rdata[rrss_pkg::EntryW-1:rrss_pkg::SliceW];
  assign burst     = ram_rdata[rrss_pkg::SliceW-1:0];
  assign run       = (rem < ts_eff) ? rem : ts_eff;
  assign rem_new   = rem - run;
  assign clock_new = clock_q + rrss_pkg::ClockW'(run);
  assign wait_new  = clock_new - rrss_pkg::ClockW'(burst);
  assign finish    = (rem_new == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrss_pkg::ST_IDLE: begin
        if (in_accept && (in_data_i.action == rrss_pkg::ACT_GRANT) && any_alive) begin
          state_d = rrss_pkg::ST_EXEC;
        end
      end
      rrss_pkg::ST_EXEC: begin
        state_d = rrss_pkg::ST_IDLE;
      end
      default: begin
        state_d = rrss_pkg::ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    case (state_q)
      rrss_pkg::ST_IDLE: in_stall_o = out_valid_q && out_stall_i;
      default:           in_stall_o = 1'b1;
    endcase
  end

  // datapath and table access
  always_comb begin
    alive_d     = alive_q;
    loaded_d    = loaded_q;
    done_d      = done_q;
    next_d      = next_q;
    idx_d       = idx_q;
    clock_d     = clock_q;
    started_d   = started_q;
    sum_tat_d   = sum_tat_q;
    sum_wt_d    = sum_wt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {rem_new, burst};
    ram_re    = 1'b0;

    if (state_q == rrss_pkg::ST_EXEC) begin
      ram_we    = 1'b1;
      clock_d   = clock_new;
      started_d = 1'b1;
      next_d    = (idx_q == rrss_pkg::IdxW'(rrss_pkg::MaxProc - 1)) ? '0 : idx_q + 1'b1;
      if (finish) begin
        alive_d[idx_q] = 1'b0;
        done_d         = done_q + 1'b1;
        sum_tat_d      = sum_tat_q + rrss_pkg::SumW'(clock_new);
        sum_wt_d       = sum_wt_q + rrss_pkg::SumW'(wait_new);
      end
      out_valid_d            = 1'b1;
      out_d.kind             = rrss_pkg::KIND_GRANTED;
      out_d.process_number   = rrss_pkg::NumW'(idx_q) + 1'b1;
      out_d.slice_start      = clock_q[rrss_pkg::TimeW-1:0];
      out_d.slice_end        = clock_new[rrss_pkg::TimeW-1:0];
      out_d.process_done     = finish;
      out_d.turnaround       = finish ? clock_new[rrss_pkg::TimeW-1:0] : '0;
      out_d.waiting          = finish ? wait_new[rrss_pkg::TimeW-1:0] : '0;
      out_d.total_turnaround = sum_tat_d;
      out_d.total_waiting    = sum_wt_d;
      out_d.finished_number  = rrss_pkg::NumW'(done_d);
    end else if (in_accept) begin
      // default result: status beat with current clock and totals
      out_d.kind             = rrss_pkg::KIND_IDLE;
      out_d.process_number   = '0;
      out_d.slice_start      = clock_q[rrss_pkg::TimeW-1:0];
      out_d.slice_end        = clock_q[rrss_pkg::TimeW-1:0];
      out_d.process_done     = 1'b0;
      out_d.turnaround       = '0;
      out_d.waiting          = '0;
      out_d.total_turnaround = sum_tat_q;
      out_d.total_waiting    = sum_wt_q;
      out_d.finished_number  = rrss_pkg::NumW'(done_q);
      out_valid_d            = 1'b1;
      case (in_data_i.action)
        rrss_pkg::ACT_LOAD: begin
          out_d.slice_start = '0;
          out_d.slice_end   = '0;
          if ((loaded_q < rrss_pkg::CntW'(rrss_pkg::MaxProc)) && !started_q) begin
            ram_we    = 1'b1;
            ram_waddr = loaded_q[rrss_pkg::IdxW-1:0];
            ram_wdata = {in_data_i.burst_length, in_data_i.burst_length};
            loaded_d  = loaded_q + 1'b1;
            if (in_data_i.burst_length == '0) begin
              done_d = done_q + 1'b1;
            end else begin
              alive_d[loaded_q[rrss_pkg::IdxW-1:0]] = 1'b1;
            end
            out_d.kind            = rrss_pkg::KIND_LOADED;
            out_d.process_number  = rrss_pkg::NumW'(loaded_d);
            out_d.finished_number = rrss_pkg::NumW'(done_d);
          end else begin
            out_d.kind = rrss_pkg::KIND_REJECTED;
          end
        end
        rrss_pkg::ACT_GRANT: begin
          if (any_alive) begin
            // result comes from the execute cycle
            out_valid_d = 1'b0;
            ram_re      = 1'b1;
            idx_d       = sel;
          end
        end
        rrss_pkg::ACT_CLEAR: begin
          alive_d   = '0;
          loaded_d  = '0;
          done_d    = '0;
          next_d    = '0;
          clock_d   = '0;
          started_d = 1'b0;
          sum_tat_d = '0;
          sum_wt_d  = '0;
          out_d.slice_start      = '0;
          out_d.slice_end        = '0;
          out_d.total_turnaround = '0;
          out_d.total_waiting    = '0;
          out_d.finished_number  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  rrss_ram #(
    .Width (rrss_pkg::EntryW),
    .Depth (rrss_pkg::MaxProc)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (sel),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rrss_pkg::ST_IDLE;
      time_slice_q <= rrss_pkg::SliceW'(1);
      alive_q      <= '0;
      loaded_q     <= '0;
      done_q       <= '0;
      next_q       <= '0;
      clock_q      <= '0;
      started_q    <= 1'b0;
      sum_tat_q    <= '0;
      sum_wt_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      alive_q     <= alive_d;
      loaded_q    <= loaded_d;
      done_q      <= done_d;
      next_q      <= next_d;
      clock_q     <= clock_d;
      started_q   <= started_d;
      sum_tat_q   <= sum_tat_d;
      sum_wt_q    <= sum_wt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        time_slice_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    out_q <= out_d;
  end

endmodule
